// File: sv/mbr_pkg.sv
// Package for the mono bitmap raster engine: operation, mode and CSR codes,
// sequencer states, word access kinds and a leading-bit helper. No dependencies.
package mbr_pkg;

   localparam int unsigned WORD_W = 32;

   typedef enum logic [3:0] {
      OP_SET_PIXEL  = 4'd0,
      OP_HSPAN      = 4'd1,
      OP_VSPAN      = 4'd2,
      OP_READ_PIXEL = 4'd3,
      OP_RECT_TEST  = 4'd4,
      OP_WIPE       = 4'd5,
      OP_WRITE_WORD = 4'd6,
      OP_READ_CLEAR = 4'd7,
      OP_READ_WORD  = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      MODE_OR     = 3'd0,
      MODE_AND    = 3'd1,
      MODE_ANDNOT = 3'd2,
      MODE_XOR    = 3'd3,
      MODE_DETECT = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_MODE   = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_WAIT,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Kinds of word access the sequencer hands to the word unit
   typedef enum logic [1:0] {
      ACC_READ,
      ACC_WRITE,
      ACC_RMW
   } acc_type;

   // Return the position (0 = leftmost) of the top set bit
   function automatic logic [4:0] lead_bit(input logic [WORD_W-1:0] m);
      logic [4:0] pos;
      pos = 5'd0;
      for (int i = 0; i < WORD_W; i++) begin
         if (m[i]) begin
            pos = 5'(WORD_W - 1 - i);
         end
      end
      return pos;
   endfunction

endpackage

// File: sv/mono_bitmap_raster_engine_core.sv
// Mono bitmap raster engine top level; depends on mbr_pkg and mbr_word_unit.
// Drawing and rect tests walk the clipped area word by word and row by row;
// wipe writes each word of the configured area in turn.
// Throughput: one command at a time, next accepted after the result beat.
// Reset clears config, detect register and sequencer; the store is not cleared.
module mono_bitmap_raster_engine_core #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic signed [15:0] req_x_first,
   input  logic signed [15:0] req_y_first,
   input  logic signed [15:0] req_x_second,
   input  logic signed [15:0] req_y_second,
   input  logic [13:0] req_word_index,
   input  logic [31:0] req_word_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pixel_on,
   output logic        rsp_collision_found,
   output logic [9:0]  rsp_collision_x,
   output logic [8:0]  rsp_collision_y,
   output logic [31:0] rsp_word_read,
   output logic        rsp_detect_flag
);

   localparam int unsigned WPR_MAX = (MAX_WIDTH + 31) / 32;
   localparam int unsigned DEPTH   = WPR_MAX * MAX_HEIGHT;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W   = ADDR_W + 1;
   localparam int unsigned WI_W    = $clog2(WPR_MAX + 1);
   localparam int unsigned YH_W    = $clog2(MAX_HEIGHT + 1);

   // Configuration
   logic [10:0] width_ff;
   logic [9:0]  height_ff;
   logic [2:0]  mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         mode_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mbr_pkg::CSR_WIDTH:  width_ff  <= csr_data[10:0];
            mbr_pkg::CSR_HEIGHT: height_ff <= csr_data[9:0];
            mbr_pkg::CSR_MODE:   mode_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // Clamp geometry
   logic signed [17:0] eff_w, eff_h;
   logic [WI_W-1:0]    per_row;
   always_comb begin
      eff_w = (32'(width_ff) > MAX_WIDTH) ? 18'(MAX_WIDTH) : 18'(width_ff);
      eff_h = (32'(height_ff) > MAX_HEIGHT) ? 18'(MAX_HEIGHT) : 18'(height_ff);
      per_row = WI_W'((eff_w + 18'sd31) >>> 5);
   end

   // Command registers
   logic [3:0]         op_ff;
   logic signed [17:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic [13:0]        idx_ff;
   logic [31:0]        val_ff;

   // Walk registers
   mbr_pkg::state_type state_ff, state_in;
   logic [YH_W-1:0]    y_ff, y_in, yend_ff, yend_in;
   logic [WI_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, wi_ff, wi_in;
   logic [1:0]         phase_ff, phase_in;  // rect: 0 first, 1 last, 2 middle
   logic [31:0]        lm_ff, lm_in, rm_ff, rm_in;
   logic [ADDR_W-1:0]  rowb_ff, rowb_in;
   logic [CNT_W-1:0]   wipe_ff, wipe_in, wipe_n_ff, wipe_n_in;

   // Result register
   logic        rv_ff, rv_in;
   logic        pix_ff, pix_in, cf_ff, cf_in;
   logic [9:0]  cx_ff, cx_in;
   logic [8:0]  cy_ff, cy_in;
   logic [31:0] wr_ff, wr_in;
   logic        df_ff, df_in;

   // Word unit interface
   logic              acc_valid, detect_clear, detect_any;
   mbr_pkg::acc_type  acc_kind;
   logic [ADDR_W-1:0] acc_addr;
   logic [31:0]       acc_mask, acc_data, rd_data;

   mbr_word_unit #(.ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_word (
      .clock, .reset, .acc_valid, .acc_kind, .acc_addr, .acc_mask, .acc_data,
      .draw_mode(mode_ff), .detect_clear, .rd_data, .detect_any
   );

   assign req_ready = (state_ff == mbr_pkg::ST_IDLE) && !rv_ff;

   // Current word of a walk and its mask
   logic [WI_W-1:0] cur_w;
   logic [31:0]     cur_m;
   logic            last_w;
   always_comb begin
      cur_w  = wi_ff;
      cur_m  = 32'hFFFF_FFFF;
      last_w = 1'b0;
      if (op_ff == mbr_pkg::OP_VSPAN || op_ff == mbr_pkg::OP_SET_PIXEL ||
          op_ff == mbr_pkg::OP_READ_PIXEL) begin
         cur_w  = lo_ff;
         cur_m  = lm_ff;
         last_w = 1'b1;
      end else if (lo_ff == hi_ff) begin
         cur_w  = lo_ff;
         cur_m  = lm_ff & rm_ff;
         last_w = 1'b1;
      end else if (phase_ff == 2'd0) begin
         cur_w = lo_ff;
         cur_m = lm_ff;
         last_w = 1'b0;
      end else if (phase_ff == 2'd1) begin
         cur_w  = hi_ff;
         cur_m  = rm_ff;
         last_w = (hi_ff == lo_ff + WI_W'(1));
      end else begin
         last_w = (wi_ff + WI_W'(1) >= hi_ff);
      end
   end

   // Setup arithmetic: clip values from command registers
   logic signed [17:0] sx1, sx2, sy1, sy2;
   logic               s_empty;
   always_comb begin
      sx1 = xa_ff; sx2 = xb_ff; sy1 = ya_ff; sy2 = yb_ff;
      s_empty = 1'b0;
      case (op_ff)
         mbr_pkg::OP_HSPAN: begin
            if (xa_ff > xb_ff) begin
               sx1 = xb_ff; sx2 = xa_ff;
            end
            if (ya_ff < 0 || ya_ff >= eff_h || sx2 < 0 || sx1 >= eff_w) s_empty = 1'b1;
            if (sx1 < 0) sx1 = '0;
            if (sx2 > eff_w) sx2 = eff_w;
            sy1 = ya_ff; sy2 = ya_ff;
         end
         mbr_pkg::OP_VSPAN: begin
            if (ya_ff > yb_ff) begin
               sy1 = yb_ff; sy2 = ya_ff;
            end
            if (xa_ff < 0 || xa_ff >= eff_w || sy2 < 0 || sy1 >= eff_h) s_empty = 1'b1;
            if (sy1 < 0) sy1 = '0;
            if (sy2 > eff_h) sy2 = eff_h;
            sy2 = sy2 - 18'sd1;
            sx1 = xa_ff;
            if (sy1 > sy2) s_empty = 1'b1;
         end
         mbr_pkg::OP_RECT_TEST: begin
            if (sx1 < 0) sx1 = '0;
            if (sx2 > eff_w) sx2 = eff_w;
            if (sy1 < 0) sy1 = '0;
            if (sy2 > eff_h - 18'sd1) sy2 = eff_h - 18'sd1;
            if (sy1 > sy2 || sx1 > sx2) s_empty = 1'b1;
         end
         default: begin
            if (xa_ff < 0 || ya_ff < 0 || xa_ff >= eff_w || ya_ff >= eff_h) s_empty = 1'b1;
            sy2 = ya_ff;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      y_in = y_ff; yend_in = yend_ff; lo_in = lo_ff; hi_in = hi_ff; wi_in = wi_ff;
      phase_in = phase_ff; lm_in = lm_ff; rm_in = rm_ff;
      rowb_in = rowb_ff; wipe_in = wipe_ff; wipe_n_in = wipe_n_ff;
      rv_in = rv_ff; pix_in = pix_ff; cf_in = cf_ff; cx_in = cx_ff; cy_in = cy_ff;
      wr_in = wr_ff; df_in = df_ff;
      acc_valid = 1'b0; acc_kind = mbr_pkg::ACC_READ;
      acc_addr = rowb_ff + ADDR_W'(cur_w); acc_mask = cur_m; acc_data = '0;
      detect_clear = 1'b0;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         mbr_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = mbr_pkg::ST_SETUP;
            end
         end
         mbr_pkg::ST_SETUP: begin
            pix_in = 1'b0; cf_in = 1'b0; cx_in = '0; cy_in = '0; wr_in = '0;
            y_in     = YH_W'(sy1);
            yend_in  = YH_W'(sy2);
            lo_in    = WI_W'(sx1 >>> 5);
            hi_in    = WI_W'(sx2 >>> 5);
            lm_in    = 32'hFFFF_FFFF >> sx1[4:0];
            rm_in    = ~(32'hFFFF_FFFF >> sx2[4:0]);
            phase_in = 2'd0;
            wi_in    = WI_W'(sx1 >>> 5) + WI_W'(1);
            rowb_in  = ADDR_W'(ADDR_W'(YH_W'(sy1)) * ADDR_W'(per_row));
            wipe_in  = '0;
            wipe_n_in = CNT_W'(CNT_W'(per_row) * CNT_W'(YH_W'(eff_h)));
            if (op_ff == mbr_pkg::OP_SET_PIXEL || op_ff == mbr_pkg::OP_VSPAN ||
                op_ff == mbr_pkg::OP_READ_PIXEL) begin
               lm_in = 32'h8000_0000 >> sx1[4:0];
            end
            case (op_ff)
               mbr_pkg::OP_SET_PIXEL, mbr_pkg::OP_HSPAN, mbr_pkg::OP_VSPAN,
               mbr_pkg::OP_READ_PIXEL, mbr_pkg::OP_RECT_TEST:
                  state_in = s_empty ? mbr_pkg::ST_DONE : mbr_pkg::ST_ISSUE;
               mbr_pkg::OP_WIPE: state_in = mbr_pkg::ST_ISSUE;
               mbr_pkg::OP_WRITE_WORD: begin
                  acc_valid = (32'(idx_ff) < DEPTH);
                  acc_kind  = mbr_pkg::ACC_WRITE;
                  acc_addr  = ADDR_W'(idx_ff);
                  acc_data  = val_ff;
                  state_in  = mbr_pkg::ST_DONE;
               end
               mbr_pkg::OP_READ_WORD: begin
                  acc_addr = ADDR_W'(idx_ff);
                  state_in = mbr_pkg::ST_WAIT;
               end
               default: state_in = mbr_pkg::ST_DONE;
            endcase
         end
         mbr_pkg::ST_ISSUE: begin
            // Present the word address; data returns next cycle
            if (op_ff == mbr_pkg::OP_WIPE) begin
               if (wipe_ff == wipe_n_ff) begin
                  state_in = mbr_pkg::ST_DONE;
               end else begin
                  acc_valid = 1'b1;
                  acc_kind  = mbr_pkg::ACC_WRITE;
                  acc_addr  = ADDR_W'(wipe_ff);
                  acc_data  = (val_ff != '0) ? 32'hFFFF_FFFF : 32'h0;
                  wipe_in   = wipe_ff + CNT_W'(1);
               end
            end else if (cur_m == '0) begin
               state_in = mbr_pkg::ST_CHECK;
            end else begin
               state_in = mbr_pkg::ST_WAIT;
            end
         end
         mbr_pkg::ST_WAIT: begin
            if (op_ff == mbr_pkg::OP_READ_WORD) begin
               acc_addr = ADDR_W'(idx_ff);
               wr_in    = (32'(idx_ff) < DEPTH) ? rd_data : '0;
               state_in = mbr_pkg::ST_DONE;
            end else begin
               state_in = mbr_pkg::ST_CHECK;
               if (op_ff == mbr_pkg::OP_READ_PIXEL) begin
                  pix_in   = |(rd_data & cur_m);
                  state_in = mbr_pkg::ST_DONE;
               end else if (op_ff == mbr_pkg::OP_RECT_TEST) begin
                  if ((rd_data & cur_m) != '0) begin
                     cf_in    = 1'b1;
                     cx_in    = 10'({cur_w, 5'd0}) + 10'(mbr_pkg::lead_bit(rd_data & cur_m));
                     cy_in    = 9'(y_ff);
                     state_in = mbr_pkg::ST_DONE;
                  end
               end else begin
                  acc_valid = 1'b1;
                  acc_kind  = mbr_pkg::ACC_RMW;
               end
            end
         end
         mbr_pkg::ST_CHECK: begin
            // Advance to the next word or row, or finish the walk
            state_in = mbr_pkg::ST_ISSUE;
            if (op_ff != mbr_pkg::OP_VSPAN && op_ff != mbr_pkg::OP_SET_PIXEL &&
                lo_ff != hi_ff && !last_w) begin
               if (phase_ff == 2'd2) begin
                  wi_in = wi_ff + WI_W'(1);
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
               if (phase_ff == 2'd1 && hi_ff == lo_ff + WI_W'(1)) begin
                  phase_in = 2'd0;
               end
            end else if (y_ff == yend_ff || op_ff == mbr_pkg::OP_SET_PIXEL ||
                         op_ff == mbr_pkg::OP_HSPAN) begin
               state_in = mbr_pkg::ST_DONE;
            end else begin
               y_in     = y_ff + YH_W'(1);
               rowb_in  = rowb_ff + ADDR_W'(per_row);
               phase_in = 2'd0;
               wi_in    = lo_ff + WI_W'(1);
            end
         end
         mbr_pkg::ST_DONE: begin
            df_in = detect_any;
            detect_clear = (op_ff == mbr_pkg::OP_READ_CLEAR);
            rv_in = 1'b1;
            state_in = mbr_pkg::ST_IDLE;
         end
         default: state_in = mbr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbr_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_operation;
         xa_ff  <= 18'(req_x_first);
         ya_ff  <= 18'(req_y_first);
         xb_ff  <= 18'(req_x_second);
         yb_ff  <= 18'(req_y_second);
         idx_ff <= req_word_index;
         val_ff <= req_word_value;
      end
      y_ff <= y_in; yend_ff <= yend_in; lo_ff <= lo_in; hi_ff <= hi_in; wi_ff <= wi_in;
      phase_ff <= phase_in; lm_ff <= lm_in; rm_ff <= rm_in;
      rowb_ff <= rowb_in; wipe_ff <= wipe_in; wipe_n_ff <= wipe_n_in;
      pix_ff <= pix_in; cf_ff <= cf_in; cx_ff <= cx_in; cy_ff <= cy_in;
      wr_ff <= wr_in; df_ff <= df_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_pixel_on        = pix_ff;
   assign rsp_collision_found = cf_ff;
   assign rsp_collision_x     = cx_ff;
   assign rsp_collision_y     = cy_ff;
   assign rsp_word_read       = wr_ff;
   assign rsp_detect_flag     = df_ff;

`ifndef ASSERT_OFF
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mbr_pkg::ST_IDLE) |-> !req_ready)
      else $error("ready while busy");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbr_pkg::ST_DONE) |=> rsp_valid)
      else $error("done without result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_read))
      else $error("result dropped");
`endif

endmodule

// File: sv/mbr_word_unit.sv
// Word unit of the mono bitmap raster engine: bitmap store plus the shared
// read-modify-write ALU applying the draw mode. Depends on mbr_pkg.
module mbr_word_unit #(
   parameter int unsigned ADDR_W = 14,
   parameter int unsigned DEPTH  = 16384
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        acc_valid,
   input  mbr_pkg::acc_type            acc_kind,
   input  logic [ADDR_W-1:0]           acc_addr,
   input  logic [mbr_pkg::WORD_W-1:0]  acc_mask,
   input  logic [mbr_pkg::WORD_W-1:0]  acc_data,
   input  logic [2:0]                  draw_mode,
   input  logic                        detect_clear,
   output logic [mbr_pkg::WORD_W-1:0]  rd_data,
   output logic                        detect_any
);

   logic [mbr_pkg::WORD_W-1:0] store_mem [DEPTH];
   logic [mbr_pkg::WORD_W-1:0] rd_ff;
   logic [mbr_pkg::WORD_W-1:0] detect_ff, detect_in;
   logic [mbr_pkg::WORD_W-1:0] new_word;
   logic                       wr_en;

   // Pick the new word from write data or the registered read and mask
   always_comb begin
      new_word  = rd_ff;
      wr_en     = 1'b0;
      detect_in = detect_ff;
      if (acc_valid && acc_kind == mbr_pkg::ACC_WRITE) begin
         new_word = acc_data;
         wr_en    = 1'b1;
      end else if (acc_valid && acc_kind == mbr_pkg::ACC_RMW) begin
         case (draw_mode)
            mbr_pkg::MODE_OR: begin
               new_word = rd_ff | acc_mask;
               wr_en    = 1'b1;
            end
            mbr_pkg::MODE_ANDNOT: begin
               new_word = rd_ff & ~acc_mask;
               wr_en    = 1'b1;
            end
            mbr_pkg::MODE_XOR: begin
               new_word = rd_ff ^ acc_mask;
               wr_en    = 1'b1;
            end
            mbr_pkg::MODE_DETECT: begin
               detect_in = detect_ff | (rd_ff & acc_mask);
            end
            default: begin
               new_word = rd_ff;
            end
         endcase
      end
      if (detect_clear) begin
         detect_in = '0;
      end
   end

   // Store: read every cycle; write on write or OR/ANDNOT/XOR modify
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[acc_addr] <= new_word;
      end
      rd_ff <= store_mem[acc_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_ff <= '0;
      end else begin
         detect_ff <= detect_in;
      end
   end

   assign rd_data    = rd_ff;
   assign detect_any = |detect_ff;

`ifndef ASSERT_OFF
   a_clear: assert property (@(posedge clock) disable iff (reset)
      detect_clear |=> detect_ff == '0)
      else $error("detect not cleared");
   a_detect_nowrite: assert property (@(posedge clock) disable iff (reset)
      (acc_valid && acc_kind == mbr_pkg::ACC_RMW && draw_mode == mbr_pkg::MODE_DETECT)
      |-> !wr_en)
      else $error("detect mode wrote store");
   a_detect_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(detect_clear) && !$past(reset) |-> (($past(detect_ff) & ~detect_ff) == '0))
      else $error("detect bits lost");
`endif

endmodule
